// ===== rtl/gpio_port_with_pin_interrupts_core_defines.svh =====
// assertion macros for the gpio port core
`ifndef GPIO_PORT_WITH_PIN_INTERRUPTS_CORE_DEFINES_SVH
`define GPIO_PORT_WITH_PIN_INTERRUPTS_CORE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define GPIO_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gpio core check failed");

// consequence in the cycle after the antecedent
`define GPIO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpio core check failed");

`endif

// ===== rtl/gpio_pkg.sv =====
// codes shared by the gpio port core
package gpio_pkg;

    localparam int WORD_WIDTH = 32;

    typedef logic [WORD_WIDTH-1:0] word_t;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] REG_DATA      = 3'd0;
    localparam logic [2:0] REG_DIRECTION = 3'd1;
    localparam logic [2:0] REG_ICR_LOW   = 3'd2;
    localparam logic [2:0] REG_ICR_HIGH  = 3'd3;
    localparam logic [2:0] REG_MASK      = 3'd4;
    localparam logic [2:0] REG_STATUS    = 3'd5;
    localparam logic [2:0] REG_BOTH_EDGE = 3'd6;

    localparam logic [1:0] MODE_LOW     = 2'd0;
    localparam logic [1:0] MODE_HIGH    = 2'd1;
    localparam logic [1:0] MODE_RISING  = 2'd2;
    localparam logic [1:0] MODE_FALLING = 2'd3;

endpackage

// ===== rtl/gpio_port_with_pin_interrupts_core.sv =====
// gpio port with per-pin interrupt detection, top level
//
//   channel | signals                                         | direction
//   in      | in_valid in_ready operation reg_index           | request in
//           | write_data pin_levels                           |
//   out     | out_valid out_ready read_data pin_drive         | result out
//           | output_enable irq                               |
//
// one request per clock while in_ready is high; the register file and the result register update at the same edge
// result appears in the cycle after the request is taken
// a held result only stalls the input when out_ready is low
// reset clears every register; pins at or above PIN_COUNT stay zero
`include "gpio_port_with_pin_interrupts_core_defines.svh"

module gpio_port_with_pin_interrupts_core #(
    parameter int PIN_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [31:0] pin_levels,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [31:0] pin_drive,
    output logic [31:0] output_enable,
    output logic        irq
);

    localparam logic [32:0] PinFull = (33'd1 << PIN_COUNT) - 33'd1;
    localparam logic [31:0] PinMask = PinFull[31:0];

    function automatic logic [31:0] icr_mask(input int first_pin);
        logic [31:0] m;
        m = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (PinMask[first_pin + k])
            begin
                m[2*k +: 2] = 2'b11;
            end
        end
        return m;
    endfunction

    localparam logic [31:0] IcrLowMask  = icr_mask(0);
    localparam logic [31:0] IcrHighMask = icr_mask(16);

    gpio_pkg::word_t data_reg,      data_next;
    gpio_pkg::word_t dir_reg,       dir_next;
    gpio_pkg::word_t icr_low_reg,   icr_low_next;
    gpio_pkg::word_t icr_high_reg,  icr_high_next;
    gpio_pkg::word_t mask_reg,      mask_next;
    gpio_pkg::word_t status_reg,    status_next;
    gpio_pkg::word_t both_edge_reg, both_edge_next;
    gpio_pkg::word_t prev_reg;

    logic            out_valid_reg;
    gpio_pkg::word_t read_data_reg, read_data_next;
    logic            irq_reg,       irq_next;

    gpio_pkg::word_t cur;
    gpio_pkg::word_t rise;
    gpio_pkg::word_t fall;
    gpio_pkg::word_t events;
    gpio_pkg::word_t clear;
    logic [63:0]     icr_all;
    logic            accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cur      = pin_levels & PinMask;
    assign rise     = cur & ~prev_reg;
    assign fall     = ~cur & prev_reg;
    assign icr_all  = {icr_high_reg, icr_low_reg};

    // read mux on the registers as they stand before the request
    always_comb
    begin
        read_data_next = '0;
        if (operation == gpio_pkg::OP_READ)
        begin
            case (reg_index)
                gpio_pkg::REG_DATA:      read_data_next = (data_reg & dir_reg) | (cur & ~dir_reg);
                gpio_pkg::REG_DIRECTION: read_data_next = dir_reg;
                gpio_pkg::REG_ICR_LOW:   read_data_next = icr_low_reg;
                gpio_pkg::REG_ICR_HIGH:  read_data_next = icr_high_reg;
                gpio_pkg::REG_MASK:      read_data_next = mask_reg;
                gpio_pkg::REG_STATUS:    read_data_next = status_reg;
                gpio_pkg::REG_BOTH_EDGE: read_data_next = both_edge_reg;
                default:                 read_data_next = '0;
            endcase
        end
    end

    // per-pin event detection
    always_comb
    begin
        events = '0;
        for (int p = 0; p < 32; p++)
        begin
            if (both_edge_reg[p])
            begin
                events[p] = rise[p] | fall[p];
            end
            else
            begin
                case (icr_all[2*p +: 2])
                    gpio_pkg::MODE_LOW:    events[p] = !cur[p];
                    gpio_pkg::MODE_HIGH:   events[p] = cur[p];
                    gpio_pkg::MODE_RISING: events[p] = rise[p];
                    default:               events[p] = fall[p];
                endcase
            end
        end
        events = events & PinMask;
    end

    // register writes
    always_comb
    begin
        data_next      = data_reg;
        dir_next       = dir_reg;
        icr_low_next   = icr_low_reg;
        icr_high_next  = icr_high_reg;
        mask_next      = mask_reg;
        both_edge_next = both_edge_reg;
        clear          = '0;
        if (operation == gpio_pkg::OP_WRITE)
        begin
            case (reg_index)
                gpio_pkg::REG_DATA:      data_next      = write_data & PinMask;
                gpio_pkg::REG_DIRECTION: dir_next       = write_data & PinMask;
                gpio_pkg::REG_ICR_LOW:   icr_low_next   = write_data & IcrLowMask;
                gpio_pkg::REG_ICR_HIGH:  icr_high_next  = write_data & IcrHighMask;
                gpio_pkg::REG_MASK:      mask_next      = write_data & PinMask;
                gpio_pkg::REG_STATUS:    clear          = write_data & PinMask;
                gpio_pkg::REG_BOTH_EDGE: both_edge_next = write_data & PinMask;
                default:                 clear          = '0;
            endcase
        end
        // an event in the same clock as its clear survives
        status_next = ((status_reg & ~clear) | events) & PinMask;
        irq_next    = |(status_next & mask_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg      <= '0;
            dir_reg       <= '0;
            icr_low_reg   <= '0;
            icr_high_reg  <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            both_edge_reg <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= '0;
            irq_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                data_reg      <= data_next;
                dir_reg       <= dir_next;
                icr_low_reg   <= icr_low_next;
                icr_high_reg  <= icr_high_next;
                mask_reg      <= mask_next;
                status_reg    <= status_next;
                both_edge_reg <= both_edge_next;
                prev_reg      <= cur;
                read_data_reg <= read_data_next;
                irq_reg       <= irq_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign pin_drive     = data_reg;
    assign output_enable = dir_reg;
    assign irq           = irq_reg;

    `GPIO_ASSERT_HOLDS(irq_tracks_status, irq_reg == (|(status_reg & mask_reg)))
    `GPIO_ASSERT_HOLDS(absent_pins_quiet, (status_reg & ~PinMask) == '0)
    `GPIO_ASSERT_NEXT(mask_write_lands,
        accept && operation == gpio_pkg::OP_WRITE && reg_index == gpio_pkg::REG_MASK,
        mask_reg == ($past(write_data) & PinMask))

endmodule
